FILE: design/prf_pkg.sv
// prf_pkg: shared constants and command/status types for the rho divisor search.
// No dependencies.
package prf_pkg;
	localparam int NumW = 63;
	localparam int PassCount = 3;
	localparam int FirstLogSteps = 18;
	localparam int StepW = 21;
	localparam logic [4:0] QOffset = 5'd17;

	typedef struct packed {
		logic load;      // latch item fields
		logic pass_init; // start a pass: compute q, start x
		logic mul_start; // begin square-add-mod of x
		logic gcd_start; // begin gcd of (x-y) mod n and n
		logic ckpt;      // y <= x
		logic [1:0] pass;
	} prf_cmd_t;

	typedef struct packed {
		logic busy;      // a working unit is running
		logic gcd_one;   // last gcd equals 1
		logic small_n;   // number below three
	} prf_sts_t;
endpackage

FILE: design/prf_datapath.sv
// prf_datapath: operand registers, shift-add modular multiplier, modulo unit and
// binary gcd unit. Depends on prf_pkg.
module prf_datapath (
	input  logic clk,
	input  logic arst_n,
	input  prf_pkg::prf_cmd_t cmd,
	output prf_pkg::prf_sts_t sts,
	input  logic [62:0] number,
	input  logic [3:0] q_rand_first,
	input  logic [3:0] q_rand_second,
	input  logic [3:0] q_rand_third,
	input  logic [30:0] x_rand_first,
	input  logic [30:0] x_rand_second,
	input  logic [30:0] x_rand_third,
	output logic [62:0] gcd_value
);
	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_QMOD = 3'd1;
	localparam logic [2:0] U_XMOD = 3'd2;
	localparam logic [2:0] U_MUL  = 3'd3;
	localparam logic [2:0] U_GCD  = 3'd4;

	logic [2:0]  unit_q;
	logic [62:0] n_q, x_q, y_q, q_q;
	logic [3:0]  qr_q [3];
	logic [30:0] xr_q [3];
	logic [63:0] mc_q, acc_q;
	logic [62:0] mp_q;
	logic [63:0] gl_q, gr_q;
	logic [5:0]  bit_q;
	logic [62:0] rem_q;
	logic [62:0] nm1;
	logic [63:0] acc_add, acc_red, mc_dbl, mc_red, rem_sh;
	logic [62:0] diff;

	assign nm1 = n_q - 63'd1;
	assign acc_add = acc_q + mc_q;
	assign acc_red = (acc_add >= {1'b0, n_q}) ? acc_add - {1'b0, n_q} : acc_add;
	assign mc_dbl = {mc_q[62:0], 1'b0};
	assign mc_red = (mc_dbl >= {1'b0, n_q}) ? mc_dbl - {1'b0, n_q} : mc_dbl;
	// restoring remainder step for x_rand mod (n-1)
	assign rem_sh = {rem_q, xr_q[cmd.pass][bit_q[4:0]]};
	assign diff = (x_q < y_q) ? n_q + x_q - y_q : x_q - y_q;

	assign sts.busy = (unit_q != U_IDLE);
	assign sts.gcd_one = ((gr_q == 64'd0) ? gl_q : gr_q) == 64'd1;
	assign sts.small_n = n_q < 63'd3;
	assign gcd_value = (gr_q == 64'd0) ? gl_q[62:0] : gr_q[62:0];

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= number;
			qr_q[0] <= q_rand_first;  qr_q[1] <= q_rand_second; qr_q[2] <= q_rand_third;
			xr_q[0] <= x_rand_first;  xr_q[1] <= x_rand_second; xr_q[2] <= x_rand_third;
		end
	end

	// working units; one runs at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= U_IDLE;
			x_q <= '0; y_q <= '0; q_q <= '0;
			mc_q <= '0; mp_q <= '0; acc_q <= '0;
			gl_q <= '0; gr_q <= '0;
			bit_q <= '0; rem_q <= '0;
		end else begin
			case (unit_q)
				U_IDLE: begin
					if (cmd.pass_init) begin
						// q = (qr+17) mod n: value below 33, reduced by repeated subtraction
						q_q <= {58'd0, 1'b0, qr_q[cmd.pass]} + {58'd0, prf_pkg::QOffset};
						unit_q <= U_QMOD;
					end else if (cmd.mul_start) begin
						mc_q <= {1'b0, x_q}; mp_q <= x_q; acc_q <= {1'b0, q_q};
						unit_q <= U_MUL;
					end else if (cmd.gcd_start) begin
						gl_q <= {1'b0, diff}; gr_q <= {1'b0, n_q};
						unit_q <= U_GCD;
					end
					if (cmd.ckpt) y_q <= x_q;
				end
				U_QMOD: begin
					if (q_q >= n_q) q_q <= q_q - n_q;
					else begin
						rem_q <= '0; bit_q <= 6'd30; unit_q <= U_XMOD;
					end
				end
				U_XMOD: begin
					rem_q <= (rem_sh >= {1'b0, nm1}) ? 63'(rem_sh - {1'b0, nm1})
						: rem_sh[62:0];
					if (bit_q == 6'd0) begin
						unit_q <= U_IDLE;
						x_q <= ((rem_sh >= {1'b0, nm1}) ? 63'(rem_sh - {1'b0, nm1})
							: rem_sh[62:0]) + 63'd1;
						y_q <= ((rem_sh >= {1'b0, nm1}) ? 63'(rem_sh - {1'b0, nm1})
							: rem_sh[62:0]) + 63'd1;
					end
					bit_q <= bit_q - 6'd1;
				end
				U_MUL: begin
					if (mp_q == 63'd0) begin
						x_q <= acc_q[62:0]; unit_q <= U_IDLE;
					end else begin
						if (mp_q[0]) acc_q <= acc_red;
						mc_q <= mc_red;
						mp_q <= mp_q >> 1;
					end
				end
				U_GCD: begin
					// one shift or one subtract per cycle
					if (gl_q == 64'd0 || gr_q == 64'd0) unit_q <= U_IDLE;
					else if (!gr_q[0]) gr_q <= gr_q >> 1;
					else if (!gl_q[0]) gl_q <= gl_q >> 1;
					else if (gl_q > gr_q) gl_q <= gl_q - gr_q;
					else gr_q <= gr_q - gl_q;
				end
				default: unit_q <= U_IDLE;
			endcase
		end
	end
endmodule

FILE: design/prf_ctrl.sv
// prf_ctrl: sequencer over passes and steps, handshake control.
// Depends on prf_pkg.
module prf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_acc,
	input  logic out_stall,
	input  prf_pkg::prf_sts_t sts,
	output prf_pkg::prf_cmd_t cmd,
	output logic idle,
	output logic out_valid_q,
	output logic found_any
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_PASS = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_GCD  = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [1:0] pass_q;
	logic [prf_pkg::StepW-1:0] step_q;
	logic started_q, hit_q;
	logic [prf_pkg::StepW-1:0] last_step;

	assign last_step = prf_pkg::StepW'((22'd1 << (prf_pkg::FirstLogSteps + 32'(pass_q))) - 22'd1);
	assign idle = (state_q == S_IDLE);
	assign out_valid_q = (state_q == S_OUT);
	assign found_any = hit_q;

	always_comb begin
		cmd = '0;
		cmd.pass = pass_q;
		cmd.load = in_acc;
		case (state_q)
			S_PASS:  cmd.pass_init = !started_q;
			S_MUL:   cmd.mul_start = !started_q;
			S_GCD:   cmd.gcd_start = !started_q;
			default: ;
		endcase
		cmd.ckpt = (state_q == S_WAIT) && !sts.busy && sts.gcd_one
			&& ((step_q & (step_q - 1'b1)) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; pass_q <= '0; step_q <= '0;
			started_q <= 1'b0; hit_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_acc) state_q <= S_CHK;
				S_CHK: begin
					pass_q <= '0; hit_q <= 1'b0;
					state_q <= sts.small_n ? S_OUT : S_PASS;
				end
				S_PASS: begin
					if (!started_q) started_q <= 1'b1;
					else if (!sts.busy) begin
						started_q <= 1'b0; step_q <= 21'd1; state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (!started_q) started_q <= 1'b1;
					else if (!sts.busy) begin started_q <= 1'b0; state_q <= S_GCD; end
				end
				S_GCD: begin
					if (!started_q) started_q <= 1'b1;
					else begin started_q <= 1'b0; state_q <= S_WAIT; end
				end
				S_WAIT: begin
					if (!sts.busy) begin
						if (!sts.gcd_one) begin hit_q <= 1'b1; state_q <= S_OUT; end
						else if (step_q == last_step) begin
							if (pass_q == 2'(prf_pkg::PassCount - 1)) state_q <= S_OUT;
							else begin pass_q <= pass_q + 2'd1; state_q <= S_PASS; end
						end else begin
							step_q <= step_q + 1'b1; state_q <= S_MUL;
						end
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/pollard_rho_factor_finder_unit.sv
// Pollard rho divisor search over 63-bit numbers: one request in, one result out.
// Work per request: up to about 1.8 million steps, each a shift-add modular
// squaring followed by a shift-and-subtract binary gcd; the request is held
// until the result is taken.
// Depends on prf_pkg, prf_ctrl, prf_datapath.
module pollard_rho_factor_finder_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [62:0] number,
	input  logic [3:0] q_rand_first,
	input  logic [3:0] q_rand_second,
	input  logic [3:0] q_rand_third,
	input  logic [30:0] x_rand_first,
	input  logic [30:0] x_rand_second,
	input  logic [30:0] x_rand_third,
	output logic out_valid,
	input  logic out_stall,
	output logic [62:0] divisor,
	output logic found
);
	prf_pkg::prf_cmd_t cmd;
	prf_pkg::prf_sts_t sts;
	logic idle, hit;
	logic [62:0] g;

	assign in_stall = !idle;

	prf_ctrl u_ctrl (.clk, .arst_n, .in_acc(in_valid && idle), .out_stall, .sts, .cmd,
		.idle, .out_valid_q(out_valid), .found_any(hit));

	prf_datapath u_dp (.clk, .arst_n, .cmd, .sts, .number, .q_rand_first, .q_rand_second,
		.q_rand_third, .x_rand_first, .x_rand_second, .x_rand_third, .gcd_value(g));

	assign divisor = hit ? g : 63'd1;
	assign found = hit && (g != 63'd1);
endmodule

FILE: design/prf_checker.sv
// prf_checker: port-level checks of the divisor search; bound to the top level.
// Depends on pollard_rho_factor_finder_unit ports only.
module prf_checker (
	input logic clk, arst_n, in_stall, out_valid, out_stall, found,
	input logic [62:0] divisor
);
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (divisor != 63'd1))) else $error("found mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accepting while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(divisor)) else $error("result dropped");
	a_nozero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> divisor != 63'd0) else $error("zero divisor");
endmodule

bind pollard_rho_factor_finder_unit prf_checker u_chk (.clk, .arst_n, .in_stall,
	.out_valid, .out_stall, .found, .divisor);

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for pollard_rho_factor_finder_unit with its own rho predictor.
// Drives divisor-search requests with random gaps and stalls and checks each result.
// Depends on the design files only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [62:0] number;
		logic [3:0]  q_rand [3];
		logic [30:0] x_rand [3];
	} rho_req_t;

	localparam int PassCount     = 3;
	localparam int FirstLogSteps = 18;
	localparam int RandomReqs    = 84;
	localparam int PauseAt       = 30;   // sender waits here for all results
	localparam int LongHoldAt    = 5;    // receiver holds off after this many results
	localparam int LongHoldLen   = 2000;
	localparam longint unsigned NumMax = 64'h7FFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [62:0] number = '0;
	logic [3:0] q_rand_first = '0, q_rand_second = '0, q_rand_third = '0;
	logic [30:0] x_rand_first = '0, x_rand_second = '0, x_rand_third = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [62:0] divisor;
	logic found;

	rho_req_t pending_reqs [$];
	logic [62:0] pending_divisors [$];
	int mismatches = 0;
	int reqs_sent = 0;
	int results_seen = 0;
	logic req_taken = 1'b0;

	pollard_rho_factor_finder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.number(number),
		.q_rand_first(q_rand_first), .q_rand_second(q_rand_second),
		.q_rand_third(q_rand_third),
		.x_rand_first(x_rand_first), .x_rand_second(x_rand_second),
		.x_rand_third(x_rand_third),
		.out_valid(out_valid), .out_stall(out_stall),
		.divisor(divisor), .found(found)
	);

	always #2 clk = ~clk;

	// x*x + c mod n by shift-and-add with conditional subtraction
	function automatic longint unsigned square_add_mod(longint unsigned x, longint unsigned c,
			longint unsigned n);
		longint unsigned mcand, mplier, acc;
		mcand = x;
		mplier = x;
		acc = c;
		while (mplier != 0) begin
			if (mplier[0]) begin
				acc += mcand;
				if (acc >= n) acc -= n;
			end
			mcand += mcand;
			if (mcand >= n) mcand -= n;
			mplier >>= 1;
		end
		return acc;
	endfunction

	// binary gcd that strips factors of two from both sides
	function automatic longint unsigned odd_part_gcd(longint unsigned l, longint unsigned r);
		while (l != 0 && r != 0) begin
			while (!r[0]) r >>= 1;
			while (!l[0]) l >>= 1;
			if (l > r) l -= r;
			else r -= l;
		end
		return (r == 0) ? l : r;
	endfunction

	// rho search with power-of-two checkpoint refresh; 1 when nothing found
	function automatic logic [62:0] rho_divisor(rho_req_t r);
		longint unsigned n, x, y, c, lim, j, diff, g;
		n = 64'(r.number);
		if (n < 3) return 63'd1;
		for (int p = 0; p < PassCount; p++) begin
			lim = 64'd1 << (p + FirstLogSteps);
			c = (64'(r.q_rand[p]) + 64'd17) % n;
			x = 64'(r.x_rand[p]) % (n - 1) + 1;
			y = x;
			for (j = 1; j < lim; j++) begin
				x = square_add_mod(x, c, n);
				diff = (x < y) ? n + x - y : x - y;
				g = odd_part_gcd(diff, n);
				if (g != 1) return g[62:0];
				if ((j & (j - 1)) == 0) y = x;
			end
		end
		return 63'd1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic add_req(logic [62:0] n, logic [3:0] q0, logic [3:0] q1, logic [3:0] q2,
			logic [30:0] x0, logic [30:0] x1, logic [30:0] x2);
		rho_req_t r;
		r.number = n;
		r.q_rand[0] = q0; r.q_rand[1] = q1; r.q_rand[2] = q2;
		r.x_rand[0] = x0; r.x_rand[1] = x1; r.x_rand[2] = x2;
		pending_reqs.push_back(r);
	endtask

	// composite with a small odd factor so the search ends quickly
	function automatic logic [62:0] quick_composite();
		int primes [12] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41};
		longint unsigned p, m, raw;
		p = 64'(primes[$urandom_range(0, 11)]);
		raw = {$urandom(), $urandom()};
		m = raw % (NumMax / p) + 1;
		if ($urandom_range(0, 9) == 0) m = (m >> $urandom_range(0, 8)) | 64'd1;
		if ($urandom_range(0, 9) == 0 && m < NumMax / (p * 4)) m = m * 4;
		return 63'(p * m);
	endfunction

	// check results, then record accepted requests
	always @(posedge clk) begin
		logic [62:0] want;
		if (out_valid && !out_stall) begin
			if (pending_divisors.size() == 0) begin
				report_mismatch("unexpected", 64'(divisor), 64'd0);
			end else begin
				want = pending_divisors.pop_front();
				if (divisor !== want) report_mismatch("divisor", 64'(divisor), 64'(want));
				if (found !== (want != 63'd1))
					report_mismatch("found", 64'(found), 64'(want != 63'd1));
			end
			results_seen++;
		end
		if (in_valid && !in_stall) pending_divisors.push_back(rho_divisor(pending_reqs[0]));
		req_taken <= in_valid && !in_stall;
	end

	// request driver
	int gap_left = 0;
	always @(negedge clk) begin
		rho_req_t r;
		logic offer;
		if (arst_n && !(in_valid && !req_taken)) begin
			if (req_taken) begin
				void'(pending_reqs.pop_front());
				reqs_sent++;
				gap_left = pick_gap();
			end
			offer = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() != 0
					&& !(reqs_sent == PauseAt && pending_divisors.size() != 0)) begin
				offer = 1'b1;
				r = pending_reqs[0];
				number <= r.number;
				q_rand_first <= r.q_rand[0];
				q_rand_second <= r.q_rand[1];
				q_rand_third <= r.q_rand[2];
				x_rand_first <= r.x_rand[0];
				x_rand_second <= r.x_rand[1];
				x_rand_third <= r.x_rand[2];
			end
			in_valid <= offer;
		end
	end

	// result-side stalls: one long hold, a quiet stretch, random otherwise
	int hold_left = 0;
	bit long_hold_done = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen == LongHoldAt && !long_hold_done) begin
				long_hold_done = 1;
				hold_left = LongHoldLen;
				out_stall <= 1'b1;
			end else if (results_seen >= 20 && results_seen < 35) begin
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < 8) begin
				hold_left = pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		// small and largest numbers, extremes of every field, x equal y cases
		add_req(63'd0, 4'd0, 4'd0, 4'd0, 31'd0, 31'd0, 31'd0);
		add_req(63'd1, 4'd15, 4'd15, 4'd15, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_req(63'd2, 4'd3, 4'd5, 4'd9, 31'd12, 31'd7, 31'd1);
		add_req(63'd3, 4'd0, 4'd0, 4'd0, 31'd0, 31'd0, 31'd0);
		add_req(63'd3, 4'd15, 4'd15, 4'd15, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_req(63'd4, 4'd1, 4'd2, 4'd3, 31'd5, 31'd6, 31'd7);
		add_req(63'd5, 4'd15, 4'd0, 4'd7, 31'd100, 31'd0, 31'd3);
		add_req(63'd9, 4'd0, 4'd15, 4'd0, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
		add_req(63'd15, 4'd8, 4'd4, 4'd2, 31'd1, 31'd2, 31'd3);
		add_req(63'd25, 4'd15, 4'd15, 4'd0, 31'd0, 31'h7FFF_FFFF, 31'd0);
		add_req(63'd1024, 4'd6, 4'd1, 4'd11, 31'd77, 31'd1234, 31'd999);
		add_req(63'd10000, 4'd2, 4'd13, 4'd4, 31'd4242, 31'd1, 31'd17);
		add_req(63'd97, 4'd0, 4'd0, 4'd0, 31'd0, 31'd0, 31'd0);
		add_req(NumMax[62:0], 4'd0, 4'd0, 4'd0, 31'd0, 31'd0, 31'd0);
		add_req(NumMax[62:0], 4'd15, 4'd15, 4'd15,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_req(63'h4000_0000_0000_0001, 4'd10, 4'd5, 4'd1, 31'h5555_5555, 31'h2AAA_AAAA, 31'd9);
		for (int i = 0; i < RandomReqs; i++) begin
			logic [62:0] n;
			if ($urandom_range(0, 9) < 2) n = 63'($urandom_range(0, 2000));
			else n = quick_composite();
			add_req(n, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), 31'($urandom()), 31'($urandom()), 31'($urandom()));
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || pending_divisors.size() != 0 || in_valid)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#400ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
